// ===== hw/rtl/palette_rle_tile_decoder_defines.svh =====
// assertion macros for the palette rle tile decoder checker
// no dependencies; included by files that hold concurrent assertions
`ifndef PALETTE_RLE_TILE_DECODER_DEFINES_SVH
`define PALETTE_RLE_TILE_DECODER_DEFINES_SVH

// property holds in the same cycle as its trigger
`define PRTD_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// property holds in the cycle after its trigger
`define PRTD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/prtd_pkg.sv =====
// shared types and constants of the palette rle tile decoder
// no dependencies; used by the interfaces and all modules
package prtd_pkg;

  localparam int unsigned TILE_PIXEL_COUNT = 256;
  localparam int unsigned POS_W = $clog2(TILE_PIXEL_COUNT);

  localparam int unsigned CODE_W  = 8;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned BYTES_W = 9;
  localparam int unsigned RUN_W   = 5;
  localparam int unsigned PAL_W   = 64;

  // config port
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned PAL_REGS  = 4;

  localparam logic [RUN_W-1:0]   MAX_RUN   = RUN_W'(16);
  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
  localparam logic [POS_W-1:0]   POS_LAST  = POS_W'(TILE_PIXEL_COUNT - 1);

  typedef struct packed {
    logic load;  // take a code word into the run registers
    logic step;  // emit one pixel into the output register
  } prtd_cmd_t;

  typedef struct packed {
    logic last_step;  // next pixel ends the run or the tile
    logic out_free;   // output register can take a pixel this cycle
  } prtd_status_t;

endpackage

// ===== hw/rtl/prtd_if.sv =====
// valid/ready channel interfaces of the palette rle tile decoder
// depends on prtd_pkg
interface prtd_cfg_if
  import prtd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PAL_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface prtd_in_if
  import prtd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink (input valid, input code_byte, output ready);
endinterface

interface prtd_out_if
  import prtd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;
  logic [INDEX_W-1:0] pixel_index;
  logic               run_last;
  logic               tile_last;
  logic [BYTES_W-1:0] bytes_used;

  modport source (output valid, output pixel_color, output pixel_index, output run_last,
                  output tile_last, output bytes_used, input ready);
  modport sink (input valid, input pixel_color, input pixel_index, input run_last,
                input tile_last, input bytes_used, output ready);
endinterface

// ===== hw/rtl/prtd_ctrl.sv =====
// control state machine: takes one code word, then steps out its run
// depends on prtd_pkg
module prtd_ctrl
  import prtd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  prtd_status_t status_i,
  output prtd_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status_i.out_free) begin
          cmd_o.step = 1'b1;
          if (status_i.last_step) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/prtd_datapath.sv =====
// datapath: palette registers, run and tile counters, output register
// depends on prtd_pkg
module prtd_datapath
  import prtd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PAL_W-1:0]     cfg_data_i,
  // code word
  input  logic [CODE_W-1:0]    code_i,
  // control
  input  prtd_cmd_t            cmd_i,
  output prtd_status_t         status_o,
  // pixel output
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [COLOR_W-1:0]   pixel_color_o,
  output logic [INDEX_W-1:0]   pixel_index_o,
  output logic                 run_last_o,
  output logic                 tile_last_o,
  output logic [BYTES_W-1:0]   bytes_used_o
);

  logic [PAL_W-1:0]   palette_q [PAL_REGS];
  logic [COLOR_W-1:0] color_q;
  logic [RUN_W-1:0]   run_rem_q, run_rem_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [BYTES_W-1:0] byte_cnt_q, byte_cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [COLOR_W-1:0] out_color_q;
  logic [INDEX_W-1:0] out_index_q;
  logic               out_run_last_q;
  logic               out_tile_last_q;
  logic [BYTES_W-1:0] out_bytes_q;

  logic [PAL_W-1:0]       pal_word;
  logic [COLOR_W-1:0]     lookup_color;
  logic [3:0]             run_nib;
  logic                   tile_end;
  logic                   run_end;
  logic [POS_W+INDEX_W-1:0] pos_ext;

  // palette: four colors per register, lowest color in the low bits
  assign pal_word     = palette_q[code_i[3:2]];
  assign lookup_color = pal_word[{code_i[1:0], 4'b0000} +: COLOR_W];
  assign run_nib      = code_i[7:4];

  assign tile_end = (pos_q == POS_LAST);
  assign run_end  = tile_end || (run_rem_q == RUN_W'(1));
  assign pos_ext  = {{INDEX_W{1'b0}}, pos_q};

  assign status_o.last_step = run_end;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PAL_REGS; i++) begin
        palette_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_index_i < CFG_IDX_W'(PAL_REGS))) begin
      palette_q[cfg_index_i[1:0]] <= cfg_data_i;
    end
  end

  always_comb begin
    run_rem_d   = run_rem_q;
    pos_d       = pos_q;
    byte_cnt_d  = byte_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.load) begin
      run_rem_d = (run_nib == 4'd0) ? MAX_RUN : {1'b0, run_nib};
      if (byte_cnt_q != BYTES_MAX) begin
        byte_cnt_d = byte_cnt_q + BYTES_W'(1);
      end
    end
    if (cmd_i.step) begin
      run_rem_d   = run_rem_q - RUN_W'(1);
      out_valid_d = 1'b1;
      if (tile_end) begin
        pos_d      = '0;
        byte_cnt_d = '0;
      end else begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      byte_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      byte_cnt_q  <= byte_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_rem_q <= run_rem_d;
    if (cmd_i.load) begin
      color_q <= lookup_color;
    end
    if (cmd_i.step) begin
      out_color_q     <= color_q;
      out_index_q     <= pos_ext[INDEX_W-1:0];
      out_run_last_q  <= run_end;
      out_tile_last_q <= tile_end;
      out_bytes_q     <= tile_end ? byte_cnt_q : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_color_o = out_color_q;
  assign pixel_index_o = out_index_q;
  assign run_last_o    = out_run_last_q;
  assign tile_last_o   = out_tile_last_q;
  assign bytes_used_o  = out_bytes_q;

endmodule

// ===== hw/rtl/palette_rle_tile_decoder.sv =====
// palette rle tile decoder: one code word in, one to sixteen pixels out
// first pixel: the taken word goes into the run registers, then steps into the output register
// run: a word gives n pixels, n its run length (1..16) or fewer at tile end, stepped out by
//   the one-pixel-per-cycle emit loop; output stalls hold the loop; the next word waits for it
// reset: palette, pixel position and byte count clear at once, no clearing pass
module palette_rle_tile_decoder
  import prtd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  prtd_cfg_if.sink cfg_i,
  prtd_in_if.sink  in_i,
  prtd_out_if.source out_o
);

  prtd_cmd_t    cmd;
  prtd_status_t status;

  assign cfg_i.ready = 1'b1;

  prtd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  prtd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .code_i        (in_i.code_byte),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .pixel_color_o (out_o.pixel_color),
    .pixel_index_o (out_o.pixel_index),
    .run_last_o    (out_o.run_last),
    .tile_last_o   (out_o.tile_last),
    .bytes_used_o  (out_o.bytes_used)
  );

endmodule

// ===== hw/rtl/prtd_checker.sv =====
// port-level checks of the palette rle tile decoder, bound to the top level
// depends on prtd_pkg and palette_rle_tile_decoder_defines.svh
`include "palette_rle_tile_decoder_defines.svh"

module prtd_checker
  import prtd_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [COLOR_W-1:0] pixel_color_i,
  input logic [INDEX_W-1:0] pixel_index_i,
  input logic               run_last_i,
  input logic               tile_last_i,
  input logic [BYTES_W-1:0] bytes_used_i
);

  // a stalled pixel keeps its color, index and byte count
  `PRTD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(pixel_color_i) && $stable(pixel_index_i) && $stable(bytes_used_i), "stalled pixel changed")
  // one code word at a time
  `PRTD_ASSERT_NEXT(a_one_word, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "second word taken during a run")
  // tile end also closes the run
  `PRTD_ASSERT_SAME(a_tile_run, clk_i, rst_ni, out_valid_i && tile_last_i, run_last_i, "tile end without run end")
  // byte count only shows on the tile's last pixel
  `PRTD_ASSERT_SAME(a_bytes_zero, clk_i, rst_ni, out_valid_i && !tile_last_i, bytes_used_i == '0, "byte count off tile end")

endmodule

bind palette_rle_tile_decoder prtd_checker u_prtd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .pixel_color_i (out_o.pixel_color),
  .pixel_index_i (out_o.pixel_index),
  .run_last_i    (out_o.run_last),
  .tile_last_i   (out_o.tile_last),
  .bytes_used_i  (out_o.bytes_used)
);

// ===== tb/tb.sv =====
// testbench of palette_rle_tile_decoder: palette writes, code words in, pixels out
// checks every pixel against a run-length predictor kept in a scoreboard class
// depends on prtd_pkg, the channel interfaces in prtd_if.sv and the decoder itself
`timescale 1ns / 100ps

module tb;
  import prtd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef enum logic [CFG_IDX_W-1:0] {
    PAL_0_3   = 0,
    PAL_4_7   = 1,
    PAL_8_11  = 2,
    PAL_12_15 = 3
  } pal_reg_e;

  localparam logic [CFG_IDX_W-1:0] REG_PAST_END = CFG_IDX_W'(PAL_REGS);
  localparam logic [CFG_IDX_W-1:0] REG_TOP      = '1;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [INDEX_W-1:0] index;
    logic               run_last;
    logic               tile_last;
    logic [BYTES_W-1:0] bytes_used;
  } pixel_t;

  class pixel_scoreboard;
    logic [PAL_W-1:0]   pal [PAL_REGS];
    int unsigned        pos;
    logic [BYTES_W-1:0] tile_bytes;
    pixel_t             pixel_q [$];
    int                 errors;

    function void clear_state();
      foreach (pal[i]) pal[i] = '0;
      pos        = 0;
      tile_bytes = '0;
      errors     = 0;
      pixel_q.delete();
    endfunction

    function void write_palette(logic [CFG_IDX_W-1:0] idx, logic [PAL_W-1:0] data);
      if (idx < PAL_REGS) pal[idx] = data;
    endfunction

    // expand one accepted code word into its pixels
    function void note_code(logic [CODE_W-1:0] code);
      int unsigned        run_len;
      logic [COLOR_W-1:0] color;
      logic               tile_end;
      pixel_t             px;
      run_len = (code[7:4] == 4'd0) ? MAX_RUN : code[7:4];
      color   = pal[code[3:2]][code[1:0]*COLOR_W +: COLOR_W];
      if (tile_bytes != BYTES_MAX) tile_bytes++;
      for (int k = 0; k < run_len; k++) begin
        tile_end      = (pos + 1 >= TILE_PIXEL_COUNT);
        px.color      = color;
        px.index      = pos[INDEX_W-1:0];
        px.run_last   = tile_end || (k + 1 == run_len);
        px.tile_last  = tile_end;
        px.bytes_used = tile_end ? tile_bytes : '0;
        pixel_q.push_back(px);
        if (tile_end) begin
          pos        = 0;
          tile_bytes = '0;
          break;
        end
        pos++;
      end
    endfunction

    function void compare(string field, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("pixel field %s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_pixel(pixel_t act);
      pixel_t exp_px;
      if (pixel_q.size() == 0) begin
        $error("pixel with nothing pending: color 0x%0h index %0d", act.color, act.index);
        errors++;
        return;
      end
      exp_px = pixel_q.pop_front();
      compare("pixel_color", exp_px.color, act.color);
      compare("pixel_index", exp_px.index, act.index);
      compare("run_last", exp_px.run_last, act.run_last);
      compare("tile_last", exp_px.tile_last, act.tile_last);
      compare("bytes_used", exp_px.bytes_used, act.bytes_used);
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  prtd_cfg_if cfg_if ();
  prtd_in_if  code_if ();
  prtd_out_if pix_if ();

  palette_rle_tile_decoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (code_if),
    .out_o  (pix_if)
  );

  pixel_scoreboard sb;
  bit              calm;        // no random idling on either side
  int unsigned     hold_reqs;   // bumped to ask the pixel side for a long hold-off
  int unsigned     cycles;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // pixel side: random stalls plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned reqs_seen;
    hold_left = 0;
    reqs_seen = 0;
    pix_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != reqs_seen) begin
        reqs_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_if.ready <= 1'b0;
      end else begin
        pix_if.ready <= calm || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  always @(posedge clk_i) begin
    pixel_t act;
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      act.color      = pix_if.pixel_color;
      act.index      = pix_if.pixel_index;
      act.run_last   = pix_if.run_last;
      act.tile_last  = pix_if.tile_last;
      act.bytes_used = pix_if.bytes_used;
      sb.check_pixel(act);
    end
  end

  // called just after a falling edge, returns just after the next one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAL_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.write_palette(idx, data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic write_all(input logic [PAL_W-1:0] p0, input logic [PAL_W-1:0] p1,
                           input logic [PAL_W-1:0] p2, input logic [PAL_W-1:0] p3);
    write_reg(PAL_0_3, p0);
    @(negedge clk_i);
    write_reg(PAL_4_7, p1);
    write_reg(PAL_8_11, p2);
    @(negedge clk_i);
    write_reg(PAL_12_15, p3);
  endtask

  // valid stays high across back-to-back words but for random idles when not calm; the caller drops it
  task automatic send_code(input logic [CODE_W-1:0] code);
    while (!calm && $urandom_range(0, 99) < 8) begin
      code_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    code_if.valid     <= 1'b1;
    code_if.code_byte <= code;
    @(posedge clk_i);
    while (!code_if.ready) @(posedge clk_i);
    sb.note_code(code);
    @(negedge clk_i);
  endtask

  // drops valid, then waits until every pixel of every word is back
  task automatic drain();
    code_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // fill the tile so that the last word's run is cut at the tile end
  task automatic cut_run_at_tile_end();
    while (TILE_PIXEL_COUNT - sb.pos > MAX_RUN)
      send_code({4'h0, 4'($urandom_range(0, 15))});
    if (TILE_PIXEL_COUNT - sb.pos == MAX_RUN)
      send_code({4'h1, 4'($urandom_range(0, 15))});
    send_code({4'h0, 4'($urandom_range(0, 15))});
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_code(CODE_W'($urandom_range(0, 255)));
  endtask

  function automatic logic [PAL_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  initial begin
    sb = new;
    sb.clear_state();
    calm      = 1'b0;
    hold_reqs = 0;
    rst_ni            = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    code_if.valid     = 1'b0;
    code_if.code_byte = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // palette still at its reset value
    send_random(4);
    drain();

    // directed: all-ones palette, writes past the last register must not land
    write_all('1, '1, '1, '1);
    write_reg(REG_PAST_END, '0);
    write_reg(REG_TOP, '0);
    send_code(8'h00);
    send_code(8'hFF);
    send_code(8'h10);
    send_code(8'h1F);
    send_code(8'hF0);
    drain();
    write_all(64'h3333_2222_1111_0000, 64'h7777_6666_5555_4444,
              64'hBBBB_AAAA_9999_8888, 64'hFFFF_EEEE_DDDD_CCCC);
    for (int k = 0; k < 16; k++) send_code({4'(k + 1), 4'(k)});
    cut_run_at_tile_end();
    drain();

    // random words against a fixed pattern, with one long output hold-off
    write_all(64'h8001_4002_2004_1008, 64'h0810_0420_0240_0180,
              64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF);
    hold_reqs++;
    send_random(80);
    drain();

    // a whole tile of single-pixel runs gives the largest byte count
    write_all(rand_word(), rand_word(), rand_word(), rand_word());
    calm = 1'b1;
    cut_run_at_tile_end();
    repeat (TILE_PIXEL_COUNT) send_code({4'h1, 4'($urandom_range(0, 15))});
    drain();
    calm = 1'b0;

    write_all('0, rand_word(), rand_word(), rand_word());
    send_random(60);
    drain();

    if (sb.pending() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
